>>> hw/rtl/spe_pkg.sv
// shared types and constants for the script push extractor
package spe_pkg;

    localparam int NUM_PUSHES_DEF = 4;
    localparam int CFG_INDEX_W    = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SIG_MAX    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECRET_MAX = 8'd1;

    localparam logic [7:0] SIG_MAX_RESET    = 8'd73;
    localparam logic [7:0] SECRET_MAX_RESET = 8'd32;

    // opcodes
    localparam logic [7:0] OP_DIRECT_LIMIT = 8'd76;
    localparam logic [7:0] OP_PUSH_LEN1    = 8'h4C;
    localparam logic [7:0] OP_PUSH_LEN2    = 8'h4D;
    localparam logic [7:0] OP_PUSH_LEN4    = 8'h4E;

    // length field sizes of the pushdata forms
    localparam logic [2:0] LEN_BYTES_PD1 = 3'd1;
    localparam logic [2:0] LEN_BYTES_PD2 = 3'd2;
    localparam logic [2:0] LEN_BYTES_PD4 = 3'd4;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_DONE       = 3'd1,
        ST_BAD_OPCODE = 3'd2,
        ST_TOO_LONG   = 3'd3,
        ST_EARLY_END  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_OPCODE = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] sig_max_len;
        logic [7:0] secret_max_len;
    } limits_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] push_index;
        status_t    status;
    } result_t;

endpackage

>>> hw/rtl/spe_cfg_regs.sv
// configuration registers holding the push length limits
module spe_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    output spe_pkg::limits_t                limits
);
    import spe_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    assign cfg_ready = 1'b1;
    assign limits    = limits_reg;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIG_MAX:    limits_next.sig_max_len    = cfg_data;
                CFG_SECRET_MAX: limits_next.secret_max_len = cfg_data;
                default:        limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.sig_max_len    <= SIG_MAX_RESET;
            limits_reg.secret_max_len <= SECRET_MAX_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

endmodule

>>> hw/rtl/spe_parser.sv
// push parser state and its one-byte update
module spe_parser #(
    parameter int NUM_PUSHES = spe_pkg::NUM_PUSHES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       script_byte,
    input  logic             end_of_script,
    input  spe_pkg::limits_t limits,
    output spe_pkg::result_t result
);
    import spe_pkg::*;

    localparam int CNT_W = (NUM_PUSHES > 1) ? $clog2(NUM_PUSHES) : 1;
    localparam logic [CNT_W-1:0] LAST_PUSH = CNT_W'(NUM_PUSHES - 1);

    phase_t           phase_reg,     phase_next;
    logic [7:0]       len_low_reg,   len_low_next;
    logic             len_high_reg,  len_high_next;
    logic [2:0]       len_left_reg,  len_left_next;
    logic [1:0]       len_pos_reg,   len_pos_next;
    logic [7:0]       data_left_reg, data_left_next;
    logic [CNT_W-1:0] pushes_reg,    pushes_next;
    status_t          status_reg,    status_next;

    logic        len_event;
    logic        finish_event;
    logic [7:0]  len_value;
    logic        len_high;
    logic [7:0]  limit;
    logic [31:0] push_ext;

    always_comb
    begin
        phase_next     = phase_reg;
        len_low_next   = len_low_reg;
        len_high_next  = len_high_reg;
        len_left_next  = len_left_reg;
        len_pos_next   = len_pos_reg;
        data_left_next = data_left_reg;
        pushes_next    = pushes_reg;
        status_next    = status_reg;
        len_event      = 1'b0;
        finish_event   = 1'b0;
        len_value      = script_byte;
        len_high       = 1'b0;
        push_ext       = 32'(pushes_reg);

        result.data_valid = 1'b0;
        result.data_byte  = 8'd0;
        result.push_index = 2'd0;

        unique case (phase_reg)
            PH_OPCODE:
            begin
                if (script_byte < OP_DIRECT_LIMIT)
                begin
                    len_event = 1'b1;
                end
                else if (script_byte == OP_PUSH_LEN1 || script_byte == OP_PUSH_LEN2
                         || script_byte == OP_PUSH_LEN4)
                begin
                    len_left_next = (script_byte == OP_PUSH_LEN1) ? LEN_BYTES_PD1 :
                                    (script_byte == OP_PUSH_LEN2) ? LEN_BYTES_PD2 :
                                                                    LEN_BYTES_PD4;
                    len_pos_next  = 2'd0;
                    len_low_next  = 8'd0;
                    len_high_next = 1'b0;
                    phase_next    = PH_LENGTH;
                end
                else
                begin
                    status_next = ST_BAD_OPCODE;
                    phase_next  = PH_DONE;
                end
            end
            PH_LENGTH:
            begin
                // low byte kept, upper bytes only matter as nonzero
                if (len_pos_reg == 2'd0)
                    len_low_next = script_byte;
                else
                    len_high_next = len_high_reg | (script_byte != 8'd0);
                len_pos_next = len_pos_reg + 2'd1;
                if (len_left_reg != 3'd0)
                    len_left_next = len_left_reg - 3'd1;
                if (len_left_next == 3'd0)
                begin
                    len_event = 1'b1;
                    len_value = len_low_next;
                    len_high  = len_high_next;
                end
            end
            PH_DATA:
            begin
                result.data_valid = 1'b1;
                result.data_byte  = script_byte;
                result.push_index = push_ext[1:0];
                if (data_left_reg != 8'd0)
                    data_left_next = data_left_reg - 8'd1;
                if (data_left_next == 8'd0)
                    finish_event = 1'b1;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // limit of the push in progress
        if (pushes_reg == '0)
            limit = 8'd0;
        else if (pushes_reg == LAST_PUSH)
            limit = limits.secret_max_len;
        else
            limit = limits.sig_max_len;

        if (len_event)
        begin
            if (len_high || (len_value > limit))
            begin
                status_next = ST_TOO_LONG;
                phase_next  = PH_DONE;
            end
            else if (len_value == 8'd0)
            begin
                finish_event = 1'b1;
            end
            else
            begin
                data_left_next = len_value;
                phase_next     = PH_DATA;
            end
        end

        if (finish_event)
        begin
            if (pushes_reg == LAST_PUSH)
            begin
                status_next = ST_DONE;
                phase_next  = PH_DONE;
            end
            else
            begin
                pushes_next = pushes_reg + CNT_W'(1);
                phase_next  = PH_OPCODE;
            end
        end

        if (end_of_script && status_next == ST_RUNNING)
            status_next = ST_EARLY_END;

        result.status = status_next;

        // next script starts from a clean parse
        if (end_of_script)
        begin
            phase_next     = PH_OPCODE;
            len_low_next   = 8'd0;
            len_high_next  = 1'b0;
            len_left_next  = 3'd0;
            len_pos_next   = 2'd0;
            data_left_next = 8'd0;
            pushes_next    = '0;
            status_next    = ST_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPCODE;
            len_low_reg   <= 8'd0;
            len_high_reg  <= 1'b0;
            len_left_reg  <= 3'd0;
            len_pos_reg   <= 2'd0;
            data_left_reg <= 8'd0;
            pushes_reg    <= '0;
            status_reg    <= ST_RUNNING;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            len_low_reg   <= len_low_next;
            len_high_reg  <= len_high_next;
            len_left_reg  <= len_left_next;
            len_pos_reg   <= len_pos_next;
            data_left_reg <= data_left_next;
            pushes_reg    <= pushes_next;
            status_reg    <= status_next;
        end
    end

endmodule

>>> hw/rtl/script_push_extractor.sv
// script push extractor: input register, push parser and result register
// a byte transfer reaches its result transfer through the input register and then the result register
// throughput: one byte per cycle while the result channel does not stall, bound by the per-byte parser state update
// each byte gives exactly one result, payload bytes carry their push index
// reset: parse state, both stage valids cleared; limits return to 73 and 32
// after a byte marked end of script the parse state returns to its reset value
module script_push_extractor #(
    parameter int NUM_PUSHES = spe_pkg::NUM_PUSHES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input byte channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      script_byte,
    input  logic                            end_of_script,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            data_valid,
    output logic [7:0]                      data_byte,
    output logic [1:0]                      push_index,
    output logic [2:0]                      status,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import spe_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eos_reg;

    // result stage
    logic       out_valid_reg;
    result_t    result_reg;

    limits_t    limits;
    result_t    result_next;
    logic       advance;
    logic       in_take;

    // the held byte moves on when the result register is free or drains now
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    spe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // parser state steps once per byte leaving the input stage
    spe_parser #(
        .NUM_PUSHES (NUM_PUSHES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .script_byte   (byte_reg),
        .end_of_script (eos_reg),
        .limits        (limits),
        .result        (result_next)
    );

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= script_byte;
            eos_reg  <= end_of_script;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign data_valid = result_reg.data_valid;
    assign data_byte  = result_reg.data_byte;
    assign push_index = result_reg.push_index;
    assign status     = result_reg.status;

endmodule
